>>> rtl/core/lwn_pkg.sv
// shared types and constants of the linear image warp block
package lwn_pkg;

    localparam logic [12:0] BOX_SAT = 13'd4096;

    typedef struct packed {
        logic        mode;
        logic [15:0] src_index;
        logic [31:0] pixel;
        logic [11:0] dest_x;
        logic [11:0] dest_y;
    } t_in_word;

    typedef struct packed {
        logic [31:0] color;
        logic        inside_res;
        logic        singular;
        logic [12:0] dest_width;
        logic [12:0] dest_height;
    } t_out_word;

    typedef enum logic [2:0] {
        REG_MAT_A      = 3'd0,
        REG_MAT_B      = 3'd1,
        REG_MAT_C      = 3'd2,
        REG_MAT_D      = 3'd3,
        REG_SRC_WIDTH  = 3'd4,
        REG_SRC_HEIGHT = 3'd5,
        REG_BACKDROP   = 3'd6
    } t_reg_index;

    // live configuration, source size already clamped
    typedef struct packed {
        logic signed [15:0] mat_a;
        logic signed [15:0] mat_b;
        logic signed [15:0] mat_c;
        logic signed [15:0] mat_d;
        logic [8:0]         src_w;
        logic [8:0]         src_h;
        logic [31:0]        backdrop;
    } t_cfg;

    // values derived from the configuration
    typedef struct packed {
        logic signed [14:0] bx0;
        logic signed [14:0] by0;
        logic [12:0]        bw;
        logic [12:0]        bh;
        logic signed [41:0] recip;
        logic               singular;
    } t_geom;

endpackage

>>> rtl/core/lwn_geom.sv
// configuration registers and the sequencer for box, determinant and reciprocal
module lwn_geom
    import lwn_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_cfg_ready,
    output t_cfg        o_cfg,
    output t_geom       o_geom,
    output logic        o_busy
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CORNER = 6'b000010,
        ST_DET1   = 6'b000100,
        ST_DET2   = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_FIN    = 6'b100000
    } t_state;

    localparam logic [8:0] RST_W = (256 > MAX_SRC_WIDTH)  ? 9'(MAX_SRC_WIDTH)  : 9'd256;
    localparam logic [8:0] RST_H = (256 > MAX_SRC_HEIGHT) ? 9'(MAX_SRC_HEIGHT) : 9'd256;

    t_state r_state;
    logic [5:0] r_cnt;
    t_cfg r_cfg;
    t_geom r_geom;

    logic signed [42:0] r_acc;
    logic signed [30:0] r_minx, r_maxx, r_miny, r_maxy;
    logic signed [32:0] r_det;
    logic [31:0] r_rem;
    logic [40:0] r_q;

    logic cfg_we;
    logic [8:0] n_w, n_h;
    logic [1:0] corner;
    logic row, term;
    logic signed [25:0] cx_far, cy_far, op_x, op_y, op;
    logic signed [15:0] coef;
    logic signed [41:0] prod;
    logic signed [42:0] sum;
    logic signed [30:0] p;
    logic signed [32:0] prod_ad, prod_bc, n_det;
    logic [31:0] dmag;
    logic [32:0] rs;
    logic ge;
    logic signed [14:0] bx0, by0;
    logic signed [15:0] ceilx, ceily;
    logic signed [16:0] bwd, bhd;

    assign cfg_we = i_cfg_valid;
    assign o_cfg_ready = 1'b1;
    assign o_cfg = r_cfg;
    assign o_geom = r_geom;
    assign o_busy = (r_state != ST_IDLE);

    assign n_w = ({4'b0, i_cfg_data[8:0]} > 13'(MAX_SRC_WIDTH))
               ? 9'(MAX_SRC_WIDTH) : i_cfg_data[8:0];
    assign n_h = ({4'b0, i_cfg_data[8:0]} > 13'(MAX_SRC_HEIGHT))
               ? 9'(MAX_SRC_HEIGHT) : i_cfg_data[8:0];

    // corner products, one per cycle until a config write restarts them: corner, row, term
    assign corner = r_cnt[3:2];
    assign row = r_cnt[1];
    assign term = r_cnt[0];
    assign cx_far = $signed({1'b0, r_cfg.src_w, 16'h0}) - 26'sd1;
    assign cy_far = $signed({1'b0, r_cfg.src_h, 16'h0}) - 26'sd1;
    assign op_x = (corner == 2'd1 || corner == 2'd2) ? cx_far : 26'sd1;
    assign op_y = corner[1] ? cy_far : 26'sd1;
    assign op = term ? op_y : op_x;
    assign coef = row ? (term ? r_cfg.mat_d : r_cfg.mat_c)
                      : (term ? r_cfg.mat_b : r_cfg.mat_a);
    assign prod = coef * op;
    assign sum = r_acc + 43'(prod);
    assign p = 31'(sum >>> 12);

    assign prod_ad = r_cfg.mat_a * r_cfg.mat_d;
    assign prod_bc = r_cfg.mat_b * r_cfg.mat_c;
    assign n_det = r_det - prod_bc;

    // restoring divide of 2^40 by the determinant magnitude
    assign dmag = r_det[32] ? 32'(-r_det) : r_det[31:0];
    assign rs = {r_rem, (r_cnt == 6'd0)};
    assign ge = rs >= {1'b0, dmag};

    assign bx0 = 15'(r_minx >>> 16);
    assign by0 = 15'(r_miny >>> 16);
    assign ceilx = 16'(($signed({r_maxx[30], r_maxx}) + 32'sd65535) >>> 16);
    assign ceily = 16'(($signed({r_maxy[30], r_maxy}) + 32'sd65535) >>> 16);
    assign bwd = 17'(ceilx) - 17'(bx0);
    assign bhd = 17'(ceily) - 17'(by0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CORNER;
            r_cnt <= '0;
            r_cfg.mat_a <= 16'sd4096;
            r_cfg.mat_b <= 16'sd0;
            r_cfg.mat_c <= 16'sd0;
            r_cfg.mat_d <= 16'sd4096;
            r_cfg.src_w <= RST_W;
            r_cfg.src_h <= RST_H;
            r_cfg.backdrop <= 32'd0;
        end else if (cfg_we) begin
            r_state <= ST_CORNER;
            r_cnt <= '0;
            unique case (t_reg_index'(i_cfg_index))
                REG_MAT_A:      r_cfg.mat_a <= i_cfg_data[15:0];
                REG_MAT_B:      r_cfg.mat_b <= i_cfg_data[15:0];
                REG_MAT_C:      r_cfg.mat_c <= i_cfg_data[15:0];
                REG_MAT_D:      r_cfg.mat_d <= i_cfg_data[15:0];
                REG_SRC_WIDTH:  r_cfg.src_w <= n_w;
                REG_SRC_HEIGHT: r_cfg.src_h <= n_h;
                REG_BACKDROP:   r_cfg.backdrop <= i_cfg_data;
                default: ;
            endcase
        end else begin
            unique case (r_state)
                ST_IDLE: ;
                ST_CORNER: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd15) begin
                        r_state <= ST_DET1;
                    end
                end
                ST_DET1: r_state <= ST_DET2;
                ST_DET2: begin
                    r_cnt <= '0;
                    r_state <= (n_det == 33'sd0) ? ST_FIN : ST_DIV;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd40) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CORNER) begin
            if (!term) begin
                r_acc <= 43'(prod);
            end else if (!row) begin
                if (corner == 2'd0 || p < r_minx) r_minx <= p;
                if (corner == 2'd0 || p > r_maxx) r_maxx <= p;
            end else begin
                if (corner == 2'd0 || p < r_miny) r_miny <= p;
                if (corner == 2'd0 || p > r_maxy) r_maxy <= p;
            end
        end
        if (r_state == ST_DET1) begin
            r_det <= prod_ad;
        end
        if (r_state == ST_DET2) begin
            r_det <= n_det;
            r_rem <= '0;
            r_q <= '0;
        end
        if (r_state == ST_DIV) begin
            r_rem <= ge ? 32'(rs - {1'b0, dmag}) : rs[31:0];
            r_q <= {r_q[39:0], ge};
        end
        if (r_state == ST_FIN) begin
            r_geom.bx0 <= bx0;
            r_geom.by0 <= by0;
            r_geom.bw <= (bwd > 17'sd4096) ? BOX_SAT : bwd[12:0];
            r_geom.bh <= (bhd > 17'sd4096) ? BOX_SAT : bhd[12:0];
            r_geom.singular <= (r_det == 33'sd0);
            r_geom.recip <= r_det[32] ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
        end
    end

endmodule

>>> rtl/core/lwn_pipe.sv
// per-pixel pipeline: inverse mapping, sample address and image store
module lwn_pipe
    import lwn_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_acc,
    input  t_in_word  i_in,
    input  t_cfg      i_cfg,
    input  t_geom     i_geom,
    output logic      o_valid,
    output t_out_word o_out
);

    typedef struct packed {
        logic        load;
        logic        in_box;
        logic [15:0] idx;
        logic [31:0] pixel;
    } t_tag;

    logic [9:1] r_v;
    t_tag r_tag [1:8];

    logic signed [32:0] r_ix1, r_iy1;
    logic signed [48:0] r_pdx2, r_pby2, r_pay2, r_pcx2;
    logic signed [37:0] r_tx3, r_ty3;
    logic [39:0] r_llx4, r_lly4;
    logic signed [40:0] r_hlx4, r_lhx4, r_hly4, r_lhy4;
    logic signed [39:0] r_hhx4, r_hhy4;
    logic signed [79:0] r_sax5, r_sbx5, r_say5, r_sby5;
    logic signed [47:0] r_sx6, r_sy6;
    logic [15:0] r_addr7;
    logic r_take7, r_take8;
    logic [31:0] r_rd8;
    t_out_word r_out;
    logic [31:0] mem [0:65535];

    t_tag tag0;
    logic signed [16:0] sumx, sumy;
    logic [79:0] px6, py6;
    logic hit;

    assign tag0.load = !i_in.mode;
    assign tag0.in_box = ({1'b0, i_in.dest_x} < i_geom.bw)
                      && ({1'b0, i_in.dest_y} < i_geom.bh);
    assign tag0.idx = i_in.src_index;
    assign tag0.pixel = i_in.pixel;
    assign sumx = 17'(i_geom.bx0) + $signed({5'b0, i_in.dest_x});
    assign sumy = 17'(i_geom.by0) + $signed({5'b0, i_in.dest_y});

    assign px6 = r_sax5 + r_sbx5;
    assign py6 = r_say5 + r_sby5;

    assign hit = !r_sx6[47] && !r_sy6[47]
              && (r_sx6 < $signed({39'b0, i_cfg.src_w}))
              && (r_sy6 < $signed({39'b0, i_cfg.src_h}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[8:1], i_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_tag[1] <= tag0;
            r_ix1 <= {sumx, 16'h8000};
            r_iy1 <= {sumy, 16'h8000};
        end
        for (int k = 2; k <= 8; k++) begin
            r_tag[k] <= r_tag[k-1];
        end

        r_pdx2 <= i_cfg.mat_d * r_ix1;
        r_pby2 <= i_cfg.mat_b * r_iy1;
        r_pay2 <= i_cfg.mat_a * r_iy1;
        r_pcx2 <= i_cfg.mat_c * r_ix1;

        r_tx3 <= 38'((50'(r_pdx2) - 50'(r_pby2)) >>> 12);
        r_ty3 <= 38'((50'(r_pay2) - 50'(r_pcx2)) >>> 12);

        // split t into 19-bit halves and the reciprocal into 21-bit halves
        r_llx4 <= r_tx3[18:0] * i_geom.recip[20:0];
        r_hlx4 <= $signed(r_tx3[37:19]) * $signed({1'b0, i_geom.recip[20:0]});
        r_lhx4 <= $signed({1'b0, r_tx3[18:0]}) * $signed(i_geom.recip[41:21]);
        r_hhx4 <= $signed(r_tx3[37:19]) * $signed(i_geom.recip[41:21]);
        r_lly4 <= r_ty3[18:0] * i_geom.recip[20:0];
        r_hly4 <= $signed(r_ty3[37:19]) * $signed({1'b0, i_geom.recip[20:0]});
        r_lhy4 <= $signed({1'b0, r_ty3[18:0]}) * $signed(i_geom.recip[41:21]);
        r_hhy4 <= $signed(r_ty3[37:19]) * $signed(i_geom.recip[41:21]);

        r_sax5 <= {r_hhx4, r_llx4};
        r_sbx5 <= (80'(r_hlx4) <<< 19) + (80'(r_lhx4) <<< 21);
        r_say5 <= {r_hhy4, r_lly4};
        r_sby5 <= (80'(r_hly4) <<< 19) + (80'(r_lhy4) <<< 21);

        // floor of the product by 2^32
        r_sx6 <= $signed(px6[79:32]);
        r_sy6 <= $signed(py6[79:32]);

        r_take7 <= !r_tag[6].load && r_tag[6].in_box && !i_geom.singular && hit;
        r_addr7 <= r_tag[6].load ? r_tag[6].idx
                 : 16'(r_sy6[15:0] * i_cfg.src_w + r_sx6[15:0]);

        r_take8 <= r_take7;

        if (r_tag[8].load) begin
            r_out <= '0;
        end else begin
            r_out.color <= r_take8 ? r_rd8 : i_cfg.backdrop;
            r_out.inside_res <= r_tag[8].in_box;
            r_out.singular <= i_geom.singular;
            r_out.dest_width <= i_geom.bw;
            r_out.dest_height <= i_geom.bh;
        end
    end

    // image store, read-first
    always_ff @(posedge i_clk) begin
        if (r_v[7] && r_tag[7].load) begin
            mem[r_addr7] <= r_tag[7].pixel;
        end
        r_rd8 <= mem[r_addr7];
    end

    assign o_valid = r_v[9];
    assign o_out = r_out;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc |-> ##9 o_valid) else $error("word lost in pipeline");
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_acc, 9)) else $error("result without accepted word");
    a_singular_bg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.singular |-> o_out.color == i_cfg.backdrop)
        else $error("singular matrix must give background");
    a_outside_bg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.inside_res
        |-> (o_out.color == 32'd0 || o_out.color == i_cfg.backdrop))
        else $error("pixel outside box was sampled");
`endif

endmodule

>>> rtl/core/linear_image_warp_nearest.sv
// top level of the nearest-neighbour linear image warp
// each accepted word gives one result strobe; throughput one word per cycle while busy is low
// the pixel path is nine register stages; the image store read feeds the final result register
// after reset and after each config write busy is high while the box, determinant and
// reciprocal are recomputed, one bit per divide step; a singular matrix skips the divide
// reset clears control and config only; the image store holds no reset value
module linear_image_warp_nearest
    import lwn_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  t_in_word    i_in_word,
    output logic        busy,
    output logic        o_res_valid,
    output t_out_word   o_res_word,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_cfg_ready
);

    t_cfg cfg;
    t_geom geom;
    logic acc;

    assign acc = start && !busy;

    lwn_geom #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
    ) u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg),
        .o_geom      (geom),
        .o_busy      (busy)
    );

    lwn_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_in    (i_in_word),
        .i_cfg   (cfg),
        .i_geom  (geom),
        .o_valid (o_res_valid),
        .o_out   (o_res_word)
    );

endmodule

>>> verif/tb_linear_image_warp_nearest.sv
// self-checking testbench for the nearest-neighbour linear image warp
module tb_linear_image_warp_nearest;
    import lwn_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    t_in_word    i_in_word;
    logic        busy;
    logic        o_res_valid;
    t_out_word   o_res_word;
    logic        i_cfg_valid;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        o_cfg_ready;

    linear_image_warp_nearest i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_in_word   (i_in_word),
        .busy        (busy),
        .o_res_valid (o_res_valid),
        .o_res_word  (o_res_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    // shadow configuration and image store
    longint    m_a, m_b, m_c, m_d, m_w, m_h;
    logic [31:0] m_bg;
    logic [31:0] image_mem [65536];
    // store entries that some queued load writes
    bit        filled [65536];

    t_in_word  pending_words [$];
    t_out_word expected_colors [$];
    int        gap_cnt;
    bit        no_gaps;
    int        errors;
    int        n_words, n_results, n_renders, n_inside, n_singular, n_cfg;
    int        idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        errors++;
    endtask

    // destination box of the four inward-pulled source corners
    function automatic void warp_box(output longint bx0, output longint by0,
                                     output longint bw, output longint bh);
        longint cx [4];
        longint cy [4];
        longint px, py, mnx, mny, mxx, mxy;
        cx = '{1, m_w * 65536 - 1, m_w * 65536 - 1, 1};
        cy = '{1, 1, m_h * 65536 - 1, m_h * 65536 - 1};
        mnx = 0; mny = 0; mxx = 0; mxy = 0;
        for (int i = 0; i < 4; i++) begin
            px = (m_a * cx[i] + m_b * cy[i]) >>> 12;
            py = (m_c * cx[i] + m_d * cy[i]) >>> 12;
            if (i == 0 || px < mnx) mnx = px;
            if (i == 0 || py < mny) mny = py;
            if (i == 0 || px > mxx) mxx = px;
            if (i == 0 || py > mxy) mxy = py;
        end
        bx0 = mnx >>> 16;
        by0 = mny >>> 16;
        bw = -((-mxx) >>> 16) - bx0;
        bh = -((-mxy) >>> 16) - by0;
        if (bw > 4096) bw = 4096;
        if (bh > 4096) bh = 4096;
    endfunction

    // store address a render samples, if it samples the source at all
    function automatic bit sample_addr(input longint dx, input longint dy,
                                       output logic [15:0] addr);
        longint bx0, by0, bw, bh, det, s, ix, iy, tx, ty, sxp, syp;
        logic signed [127:0] p;
        logic signed [127:0] q;
        addr = '0;
        warp_box(bx0, by0, bw, bh);
        det = m_a * m_d - m_b * m_c;
        if (det == 0 || dx >= bw || dy >= bh) return 1'b0;
        s = (64'sd1 <<< 40) / det;
        ix = (bx0 + dx) * 65536 + 32768;
        iy = (by0 + dy) * 65536 + 32768;
        tx = (m_d * ix - m_b * iy) >>> 12;
        ty = (m_a * iy - m_c * ix) >>> 12;
        q = s;
        p = tx; p = (p * q) >>> 32; sxp = longint'(p);
        p = ty; p = (p * q) >>> 32; syp = longint'(p);
        if (sxp >= 0 && sxp < m_w && syp >= 0 && syp < m_h) begin
            addr = 16'((syp * m_w + sxp) & 65535);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_out_word warp_pixel(input t_in_word w);
        t_out_word r;
        longint bx0, by0, bw, bh, dx, dy;
        logic [15:0] addr;
        r = '0;
        if (w.mode == 1'b0) begin
            image_mem[w.src_index] = w.pixel;
            return r;
        end
        warp_box(bx0, by0, bw, bh);
        dx = w.dest_x;
        dy = w.dest_y;
        r.inside_res = (dx < bw) && (dy < bh);
        r.singular = (m_a * m_d - m_b * m_c == 0);
        r.dest_width = bw[12:0];
        r.dest_height = bh[12:0];
        r.color = m_bg;
        if (sample_addr(dx, dy, addr))
            r.color = image_mem[addr];
        return r;
    endfunction

    // driver: start held until the word is taken, random gap between words unless no_gaps is set
    always @(posedge i_clk) begin
        logic go;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_cnt = 0;
        end else begin
            go = start;
            if (start && !busy) begin
                expected_colors.push_back(warp_pixel(i_in_word));
                n_words++;
                if (i_in_word.mode) n_renders++;
                go = 1'b0;
            end
            if (!go) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                end else if (pending_words.size() > 0) begin
                    i_in_word <= pending_words.pop_front();
                    go = 1'b1;
                    gap_cnt = no_gaps ? 0 : $urandom_range(0, 6);
                end
            end
            start <= go;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_res_valid) begin
            n_results++;
            if (expected_colors.size() == 0) begin
                $display("result word with nothing expected");
                errors++;
            end else begin
                e = expected_colors.pop_front();
                if (e.inside_res) n_inside++;
                if (e.singular) n_singular++;
                if (o_res_word.color !== e.color) report("color", o_res_word.color, e.color);
                if (o_res_word.inside_res !== e.inside_res)
                    report("inside", o_res_word.inside_res, e.inside_res);
                if (o_res_word.singular !== e.singular)
                    report("singular", o_res_word.singular, e.singular);
                if (o_res_word.dest_width !== e.dest_width)
                    report("width", o_res_word.dest_width, e.dest_width);
                if (o_res_word.dest_height !== e.dest_height)
                    report("height", o_res_word.dest_height, e.dest_height);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_valid || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d words expected", expected_colors.size());
            $display("linear_image_warp_nearest verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic cfg_write(input t_reg_index idx, input logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_cfg++;
        case (idx)
            REG_MAT_A:      m_a = longint'($signed(v[15:0]));
            REG_MAT_B:      m_b = longint'($signed(v[15:0]));
            REG_MAT_C:      m_c = longint'($signed(v[15:0]));
            REG_MAT_D:      m_d = longint'($signed(v[15:0]));
            REG_SRC_WIDTH:  m_w = (v[8:0] > 256) ? 256 : v[8:0];
            REG_SRC_HEIGHT: m_h = (v[8:0] > 256) ? 256 : v[8:0];
            REG_BACKDROP:   m_bg = v;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // wait out everything in flight
    task automatic drain();
        while (pending_words.size() != 0 || start || expected_colors.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    function automatic t_in_word render_word(input int x, input int y);
        t_in_word w;
        w = '0;
        w.mode = 1'b1;
        w.src_index = 16'($urandom);
        w.pixel = $urandom;
        w.dest_x = 12'(x);
        w.dest_y = 12'(y);
        return w;
    endfunction

    function automatic t_in_word load_word(input int idx, input logic [31:0] px);
        t_in_word w;
        w = '0;
        w.src_index = 16'(idx);
        w.pixel = px;
        w.dest_x = 12'($urandom);
        w.dest_y = 12'($urandom);
        return w;
    endfunction

    function automatic void push_load(input int idx, input logic [31:0] px);
        pending_words.push_back(load_word(idx, px));
        filled[16'(idx)] = 1'b1;
    endfunction

    // a render that would sample a never-loaded entry gets a load in front
    function automatic void push_render(input int x, input int y);
        logic [15:0] addr;
        if (sample_addr(x, y, addr) && !filled[addr])
            push_load(int'(addr), $urandom);
        pending_words.push_back(render_word(x, y));
    endfunction

    task automatic warp_phase(input int a, input int b, input int c, input int d,
                              input int w, input int h, input int n);
        longint bx0, by0, bw, bh;
        int xr, yr;
        drain();
        cfg_write(REG_MAT_A, {16'($urandom_range(0, 65535)), a[15:0]});
        cfg_write(REG_MAT_B, {16'($urandom_range(0, 65535)), b[15:0]});
        cfg_write(REG_MAT_C, {16'($urandom_range(0, 65535)), c[15:0]});
        cfg_write(REG_MAT_D, {16'($urandom_range(0, 65535)), d[15:0]});
        cfg_write(REG_SRC_WIDTH, {16'($urandom_range(0, 65535)), 7'd0, w[8:0]});
        cfg_write(REG_SRC_HEIGHT, {16'($urandom_range(0, 65535)), 7'd0, h[8:0]});
        cfg_write(REG_BACKDROP, $urandom);
        warp_box(bx0, by0, bw, bh);
        xr = (bw + 1 > 4095) ? 4095 : int'(bw + 1);
        yr = (bh + 1 > 4095) ? 4095 : int'(bh + 1);
        push_render(0, 0);
        push_render(xr, yr);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: push_load($urandom_range(0, 65535), $urandom);
                3:       push_render($urandom_range(0, 4095), $urandom_range(0, 4095));
                default: push_render($urandom_range(0, xr), $urandom_range(0, yr));
            endcase
        end
    endtask

    initial begin
        errors = 0;
        n_words = 0; n_results = 0; n_renders = 0; n_inside = 0; n_singular = 0; n_cfg = 0;
        no_gaps = 1'b1;
        m_a = 4096; m_b = 0; m_c = 0; m_d = 4096; m_w = 256; m_h = 256; m_bg = '0;
        i_rst_n <= 1'b0;
        i_in_word <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at reset configuration, back to back
        push_load(0, 32'hffff_ffff);
        push_load(65535, 32'h0);
        push_render(0, 0);
        push_render(255, 255);
        push_render(256, 0);
        push_render(0, 256);
        push_render(4095, 4095);
        push_render(128, 77);
        drain();
        no_gaps = 1'b0;

        warp_phase(4096, 0, 0, 4096, 256, 256, 25);
        warp_phase(8192, 0, 0, 8192, 100, 50, 25);
        warp_phase(2896, -2896, 2896, 2896, 64, 64, 25);
        warp_phase(-4096, 0, 0, 4096, 30, 200, 25);
        warp_phase(32767, -32768, -32768, 32767, 256, 256, 25);
        warp_phase(4096, 4096, 4096, 4096, 16, 16, 15);
        warp_phase(0, 0, 0, 0, 8, 8, 15);
        warp_phase(4096, 0, 0, 4096, 0, 5, 15);
        warp_phase(-32768, 1234, -777, -32768, 511, 300, 25);
        warp_phase(4096, 0, 0, -4096, 1, 1, 15);
        warp_phase(512, 300, -200, 700, 256, 256, 25);
        warp_phase(32767, 0, 0, 32767, 256, 256, 25);
        warp_phase(-3000, 5000, 2500, 1000, 40, 90, 25);
        drain();
        repeat (20) @(posedge i_clk);

        $display("covered %0d words (%0d renders, %0d inside the box, %0d singular)",
                 n_words, n_renders, n_inside, n_singular);
        $display("%0d register writes, %0d results checked, %0d mismatches",
                 n_cfg, n_results, errors);
        if (errors == 0 && expected_colors.size() == 0) begin
            $display("linear_image_warp_nearest verification clean");
        end else begin
            $display("linear_image_warp_nearest verification failed");
        end
        $finish;
    end

endmodule
